### rtl/mspt_pkg.sv
`timescale 1ns / 1ps

package mspt_pkg;

    localparam int COORD_W  = 40;
    localparam int SCALE_W  = 40;
    localparam int OFF_W    = 16;
    localparam int DIM_W    = 16;
    localparam int PT_W     = 32;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SPLIT_W  = 20;
    localparam int PROD_W   = 82;
    localparam int AX_LAT   = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [COORD_W-1:0] LEFT_X_RST   = '0;
    localparam logic signed [COORD_W-1:0] BOTTOM_Y_RST = '0;
    localparam logic signed [OFF_W-1:0]   OFFSET_RST   = '0;
    localparam logic [DIM_W-1:0]          WIDTH_RST    = 16'd640;
    localparam logic [DIM_W-1:0]          HEIGHT_RST   = 16'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_X        = 3'd0,
        CFG_BOTTOM_Y      = 3'd1,
        CFG_SCALE_X       = 3'd2,
        CFG_SCALE_Y       = 3'd3,
        CFG_OFFSET_X      = 3'd4,
        CFG_OFFSET_Y      = 3'd5,
        CFG_SCREEN_WIDTH  = 3'd6,
        CFG_SCREEN_HEIGHT = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic first_point;
        logic last_point;
    } pt_flags_t;

endpackage

### rtl/mspt_axis.sv
`timescale 1ns / 1ps

module mspt_axis #(
    parameter int COORD_FRAC_BITS = 8,
    parameter int SCALE_FRAC_BITS = 32
) (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic signed [mspt_pkg::COORD_W-1:0]     p_in,
    input  logic signed [mspt_pkg::COORD_W-1:0]     q_in,
    input  logic        [mspt_pkg::SCALE_W-1:0]     scale,
    input  logic signed [mspt_pkg::OFF_W-1:0]       offset,
    output logic signed [mspt_pkg::PT_W-1:0]        pt_out
);

    localparam int T    = COORD_FRAC_BITS + SCALE_FRAC_BITS;
    localparam int PW   = mspt_pkg::PROD_W;
    localparam int SP   = mspt_pkg::SPLIT_W;
    localparam int CW   = mspt_pkg::COORD_W;
    localparam int DW   = mspt_pkg::DIFF_W;
    localparam int SW   = mspt_pkg::SCALE_W;
    localparam int DH_W = DW - SP;
    localparam int SH_W = SW - SP;
    localparam int PT_W = mspt_pkg::PT_W;

    localparam logic signed [PW-1:0] HALF   = {{(PW-1){1'b0}}, 1'b1} << (T - 1);
    localparam logic signed [PW-1:0] SAT_HI = {{(PW-PT_W+1){1'b0}}, {(PT_W-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - {{(PW-1){1'b0}}, 1'b1};

    logic signed [CW-1:0]        p_reg, q_reg;
    logic signed [DW-1:0]        d_reg, d_next;
    logic [2*SP-1:0]             pp_ll_reg, pp_ll_next;
    logic [SP+SH_W-1:0]          pp_lh_reg, pp_lh_next;
    logic signed [DH_W+SP:0]     pp_hl_reg, pp_hl_next;
    logic signed [DH_W+SH_W:0]   pp_hh_reg, pp_hh_next;
    logic signed [PW-1:0]        off_al;
    logic signed [PW-1:0]        sum_a_reg, sum_a_next;
    logic signed [PW-1:0]        sum_b_reg, sum_b_next;
    logic signed [PW-1:0]        w_reg, w_next;
    logic signed [PW-1:0]        qt_reg, qt_next;
    logic                        dec_reg, dec_next;
    logic signed [PW-1:0]        r_full;
    logic signed [PT_W-1:0]      pt_reg, pt_next;

    // difference, sign extended
    assign d_next = DW'(p_reg) - DW'(q_reg);

    // partial products
    assign pp_ll_next = d_reg[SP-1:0] * scale[SP-1:0];
    assign pp_lh_next = d_reg[SP-1:0] * scale[SW-1:SP];
    assign pp_hl_next = $signed(d_reg[DW-1:SP]) * $signed({1'b0, scale[SP-1:0]});
    assign pp_hh_next = $signed(d_reg[DW-1:SP]) * $signed({1'b0, scale[SW-1:SP]});

    assign off_al = PW'(offset) <<< T;

    assign sum_a_next = PW'(pp_ll_reg) + (PW'(pp_lh_reg) << SP) + off_al;
    assign sum_b_next = (PW'(pp_hl_reg) <<< SP) + (PW'(pp_hh_reg) <<< (2 * SP)) + HALF;

    assign w_next = sum_a_reg + sum_b_reg;

    // halves away from zero: negative values on an exact half step round down one less
    assign qt_next  = w_reg >>> T;
    assign dec_next = (w_reg < HALF) && (w_reg[T-1:0] == '0);

    assign r_full = qt_reg - PW'(dec_reg);

    always_comb begin
        if (r_full > SAT_HI) begin
            pt_next = {1'b0, {(PT_W-1){1'b1}}};
        end else if (r_full < SAT_LO) begin
            pt_next = {1'b1, {(PT_W-1){1'b0}}};
        end else begin
            pt_next = r_full[PT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg     <= p_in;
            q_reg     <= q_in;
            d_reg     <= d_next;
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
            pp_hh_reg <= pp_hh_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            w_reg     <= w_next;
            qt_reg    <= qt_next;
            dec_reg   <= dec_next;
            pt_reg    <= pt_next;
        end
    end

    assign pt_out = pt_reg;

endmodule

### rtl/mspt_bbox.sv
`timescale 1ns / 1ps

module mspt_bbox (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                upd,
    input  logic signed [mspt_pkg::PT_W-1:0]    pt_x,
    input  logic signed [mspt_pkg::PT_W-1:0]    pt_y,
    input  mspt_pkg::pt_flags_t                 flags,
    input  logic        [mspt_pkg::DIM_W-1:0]   screen_width,
    input  logic        [mspt_pkg::DIM_W-1:0]   screen_height,
    output logic                                visible
);

    localparam int PT_W  = mspt_pkg::PT_W;
    localparam int DIM_W = mspt_pkg::DIM_W;

    logic signed [PT_W-1:0] min_x_reg, min_x_next;
    logic signed [PT_W-1:0] max_x_reg, max_x_next;
    logic signed [PT_W-1:0] min_y_reg, min_y_next;
    logic signed [PT_W-1:0] max_y_reg, max_y_next;
    logic signed [PT_W:0]   lim_x, lim_y;

    always_comb begin
        if (flags.first_point) begin
            min_x_next = pt_x;
            max_x_next = pt_x;
            min_y_next = pt_y;
            max_y_next = pt_y;
        end else begin
            min_x_next = (pt_x < min_x_reg) ? pt_x : min_x_reg;
            max_x_next = (pt_x > max_x_reg) ? pt_x : max_x_reg;
            min_y_next = (pt_y < min_y_reg) ? pt_y : min_y_reg;
            max_y_next = (pt_y > max_y_reg) ? pt_y : max_y_reg;
        end
    end

    assign lim_x = $signed({{(PT_W+1-DIM_W){1'b0}}, screen_width});
    assign lim_y = $signed({{(PT_W+1-DIM_W){1'b0}}, screen_height});

    assign visible = flags.last_point
                     && !max_x_next[PT_W-1]
                     && ($signed({min_x_next[PT_W-1], min_x_next}) < lim_x)
                     && !max_y_next[PT_W-1]
                     && ($signed({min_y_next[PT_W-1], min_y_next}) < lim_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
        end else if (upd) begin
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
        end
    end

`ifndef SYNTHESIS
    a_box_x_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        min_x_reg <= max_x_reg)
        else $error("box x minimum above maximum");

    a_box_y_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        min_y_reg <= max_y_reg)
        else $error("box y minimum above maximum");
`endif

endmodule

### rtl/map_to_screen_point_transform.sv
`timescale 1ns / 1ps

// registered steps: input, difference, products, partial sums, sum, rounding, saturation, output
// throughput: one point per cycle; the whole pipeline holds while the output register is stalled
// the 41x40 product: four partial products of at most 21x21, one register stage each step
// reset (synchronous, active low): pipeline and output emptied, bounding box cleared to zero,
// configuration registers back to their defaults

module map_to_screen_point_transform #(
    parameter int COORD_FRAC_BITS = 8,
    parameter int SCALE_FRAC_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,    // map_x, map_y
    input  logic [0:0]  s_tuser,    // first_point
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // screen_x, screen_y
    output logic [0:0]  m_tuser,    // visible
    output logic        m_tlast
);

    localparam int CW  = mspt_pkg::COORD_W;
    localparam int SW  = mspt_pkg::SCALE_W;
    localparam int OW  = mspt_pkg::OFF_W;
    localparam int DMW = mspt_pkg::DIM_W;
    localparam int PTW = mspt_pkg::PT_W;
    localparam int LAT = mspt_pkg::AX_LAT;

    localparam logic [SW-1:0] SCALE_RST = SW'(64'd1 << SCALE_FRAC_BITS);

    logic signed [CW-1:0]  left_x_reg, bottom_y_reg;
    logic [SW-1:0]         scale_x_reg, scale_y_reg;
    logic signed [OW-1:0]  offset_x_reg, offset_y_reg;
    logic [DMW-1:0]        width_reg, height_reg;

    logic                  en;
    logic [LAT-1:0]        vld_reg;
    mspt_pkg::pt_flags_t   flags_reg [LAT];
    mspt_pkg::pt_flags_t   flags_in;

    logic signed [PTW-1:0] sx, sy;
    logic                  upd;
    logic                  vis;

    logic                  m_tvalid_reg;
    logic [63:0]           m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  m_tuser_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_x_reg   <= mspt_pkg::LEFT_X_RST;
            bottom_y_reg <= mspt_pkg::BOTTOM_Y_RST;
            scale_x_reg  <= SCALE_RST;
            scale_y_reg  <= SCALE_RST;
            offset_x_reg <= mspt_pkg::OFFSET_RST;
            offset_y_reg <= mspt_pkg::OFFSET_RST;
            width_reg    <= mspt_pkg::WIDTH_RST;
            height_reg   <= mspt_pkg::HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (mspt_pkg::cfg_index_t'(cfg_index))
                mspt_pkg::CFG_LEFT_X:        left_x_reg   <= cfg_wdata;
                mspt_pkg::CFG_BOTTOM_Y:      bottom_y_reg <= cfg_wdata;
                mspt_pkg::CFG_SCALE_X:       scale_x_reg  <= cfg_wdata;
                mspt_pkg::CFG_SCALE_Y:       scale_y_reg  <= cfg_wdata;
                mspt_pkg::CFG_OFFSET_X:      offset_x_reg <= cfg_wdata[OW-1:0];
                mspt_pkg::CFG_OFFSET_Y:      offset_y_reg <= cfg_wdata[OW-1:0];
                mspt_pkg::CFG_SCREEN_WIDTH:  width_reg    <= cfg_wdata[DMW-1:0];
                mspt_pkg::CFG_SCREEN_HEIGHT: height_reg   <= cfg_wdata[DMW-1:0];
            endcase
        end
    end

    // pipeline advances whenever the output register is free or being drained
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    assign flags_in.first_point = s_tuser[0];
    assign flags_in.last_point  = s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg[0] <= flags_in;
            for (int i = 1; i < LAT; i++) begin
                flags_reg[i] <= flags_reg[i-1];
            end
        end
    end

    mspt_axis #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_axis_x (
        .aclk   (aclk),
        .en     (en),
        .p_in   (s_tdata[CW-1:0]),
        .q_in   (left_x_reg),
        .scale  (scale_x_reg),
        .offset (offset_x_reg),
        .pt_out (sx)
    );

    mspt_axis #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_axis_y (
        .aclk   (aclk),
        .en     (en),
        .p_in   (bottom_y_reg),
        .q_in   (s_tdata[2*CW-1:CW]),
        .scale  (scale_y_reg),
        .offset (offset_y_reg),
        .pt_out (sy)
    );

    assign upd = en && vld_reg[LAT-1];

    mspt_bbox u_bbox (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .upd           (upd),
        .pt_x          (sx),
        .pt_y          (sy),
        .flags         (flags_reg[LAT-1]),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .visible       (vis)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {sy, sx};
            m_tlast_reg <= flags_reg[LAT-1].last_point;
            m_tuser_reg <= vis;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_vis_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tuser[0])
        else $error("visible set on a transfer that does not close the set");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule
